[rtl/core/mmbd_pkg.sv]
`timescale 1ns / 1ps

package mmbd_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned LevelW    = 4;
  localparam int unsigned IdxW      = 20;
  localparam int unsigned CountW    = 21;
  localparam int unsigned WidthW    = 13;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 21;
  localparam int unsigned TdataW    = 72;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  localparam logic [CountW-1:0] MaxSamples = CountW'(1048576);
  localparam logic [WidthW-1:0] MaxPixels  = WidthW'(4096);

  typedef enum logic [CfgIdxW-1:0] {
    CfgSampleCount = 1'b0,
    CfgPixelWidth  = 1'b1
  } cfg_reg_e;

  // lowest bits first in tdata: value, position, valid, level
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              valid;
    logic [ValueW-1:0] position;
    logic [ValueW-1:0] value;
  } sample_t;

  localparam int unsigned SampleW = $bits(sample_t);

  typedef struct packed {
    logic    last;
    sample_t s;
  } result_t;

  typedef struct packed {
    logic [CountW-1:0] n;
    logic [WidthW-1:0] w;
    logic [CountW-1:0] n_minus_w;
    logic              pass;
  } cfg_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic logic [CountW-1:0] sat_count(input logic [CountW-1:0] d);
    logic [CountW-1:0] r;
    r = d;
    if (d == '0) r = CountW'(1);
    else if (d > MaxSamples) r = MaxSamples;
    return r;
  endfunction

  function automatic logic [WidthW-1:0] sat_width(input logic [WidthW-1:0] d);
    logic [WidthW-1:0] r;
    r = d;
    if (d == '0) r = WidthW'(1);
    else if (d > MaxPixels) r = MaxPixels;
    return r;
  endfunction

  function automatic logic pass_mode(input logic [CountW-1:0] n,
                                     input logic [WidthW-1:0] w);
    logic [CountW-1:0] w2;
    w2 = {{(CountW-WidthW-1){1'b0}}, w, 1'b0};
    return n <= w2;
  endfunction

endpackage

[rtl/core/mmbd_cfg_regs.sv]
`timescale 1ns / 1ps

module mmbd_cfg_regs import mmbd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o,
  output logic                restart_o
);

  cfg_t cfg_q, cfg_d;
  logic [CountW-1:0] new_n;
  logic [WidthW-1:0] new_w;

  always_comb begin
    cfg_d = cfg_q;
    new_n = sat_count(cfg_data_i[CountW-1:0]);
    new_w = sat_width(cfg_data_i[WidthW-1:0]);
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgSampleCount: begin
          cfg_d.n         = new_n;
          cfg_d.n_minus_w = new_n - {{(CountW-WidthW){1'b0}}, cfg_q.w};
          cfg_d.pass      = pass_mode(new_n, cfg_q.w);
        end
        CfgPixelWidth: begin
          cfg_d.w         = new_w;
          cfg_d.n_minus_w = cfg_q.n - {{(CountW-WidthW){1'b0}}, new_w};
          cfg_d.pass      = pass_mode(cfg_q.n, new_w);
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.n         <= CountW'(1);
      cfg_q.w         <= WidthW'(1);
      cfg_q.n_minus_w <= '0;
      cfg_q.pass      <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o     = cfg_q;
  assign restart_o = cfg_valid_i;

endmodule

[rtl/core/mmbd_binner.sv]
`timescale 1ns / 1ps

module mmbd_binner import mmbd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    restart_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  sample_t in_sample_i,
  input  logic    room_i,
  output push_t   push_o
);

  typedef struct packed {
    sample_t         s;
    logic [IdxW-1:0] idx;
  } bin_entry_t;

  logic              vld_q;
  sample_t           smp_q;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0]   acc_q, acc_d;
  bin_entry_t        min_q, min_d, max_q, max_d;
  logic              fire;
  logic [CountW-1:0] idx_plus, acc_sum, acc_wrap;
  logic              line_end, first, bin_end, min_sel, max_sel;
  bin_entry_t        cur;

  assign fire       = vld_q && room_i;
  assign in_ready_o = !vld_q || room_i;

  always_comb begin
    idx_plus = {1'b0, cnt_q} + CountW'(1);
    line_end = idx_plus >= cfg_i.n;
    first    = (acc_q == '0) || ({1'b0, acc_q} > cfg_i.n_minus_w);
    acc_sum  = {1'b0, acc_q} + {{(CountW-WidthW){1'b0}}, cfg_i.w};
    acc_wrap = (acc_sum >= cfg_i.n) ? acc_sum - cfg_i.n : acc_sum;
    bin_end  = (acc_wrap == '0) || (acc_wrap > cfg_i.n_minus_w) || line_end;

    cur.s   = smp_q;
    cur.idx = cnt_q;
    min_sel = first || (smp_q.valid && (!min_q.s.valid ||
              ($signed(smp_q.value) < $signed(min_q.s.value))));
    max_sel = first || (smp_q.valid && (!max_q.s.valid ||
              ($signed(max_q.s.value) < $signed(smp_q.value))));
    min_d = min_sel ? cur : min_q;
    max_d = max_sel ? cur : max_q;

    push_o           = '0;
    push_o.res0.s    = min_d.s;
    push_o.res0.last = line_end;
    push_o.res1.s    = max_d.s;
    push_o.res1.last = line_end;
    if (cfg_i.pass) begin
      push_o.num    = fire ? 2'd1 : 2'd0;
      push_o.res0.s = smp_q;
    end else if (fire && bin_end) begin
      if (min_d.idx == max_d.idx) begin
        push_o.num = 2'd1;
      end else if (min_d.idx < max_d.idx) begin
        push_o.num       = 2'd2;
        push_o.res0.last = 1'b0;
      end else begin
        push_o.num       = 2'd2;
        push_o.res0.s    = max_d.s;
        push_o.res0.last = 1'b0;
        push_o.res1.s    = min_d.s;
      end
    end

    cnt_d = cnt_q;
    acc_d = acc_q;
    if (restart_i) begin
      cnt_d = '0;
      acc_d = '0;
    end else if (fire) begin
      if (line_end) begin
        cnt_d = '0;
        acc_d = '0;
      end else begin
        cnt_d = idx_plus[IdxW-1:0];
        if (!cfg_i.pass) acc_d = acc_wrap[IdxW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
      acc_q <= '0;
      min_q <= '0;
      max_q <= '0;
    end else begin
      if (in_ready_o) vld_q <= in_valid_i;
      cnt_q <= cnt_d;
      acc_q <= acc_d;
      if (fire && !cfg_i.pass) begin
        min_q <= min_d;
        max_q <= max_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) smp_q <= in_sample_i;
  end

endmodule

[rtl/core/mmbd_out_fifo.sv]
`timescale 1ns / 1ps

module mmbd_out_fifo import mmbd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  result_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wptr_q, rptr_q, wptr_p1;
  logic [FifoCntW-1:0] cnt_q;
  logic                pop;

  assign pop         = (cnt_q != '0) && out_ready_i;
  assign room_o      = cnt_q <= FifoCntW'(FifoDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_o       = mem_q[rptr_q];
  assign wptr_p1     = wptr_q + FifoPtrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + FifoPtrW'(push_i.num);
      if (pop) rptr_q <= rptr_q + FifoPtrW'(1);
      cnt_q <= cnt_q + FifoCntW'(push_i.num) - FifoCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wptr_q] <= push_i.res0;
    if (push_i.num == 2'd2) mem_q[wptr_p1] <= push_i.res1;
  end

endmodule

[rtl/core/min_max_bin_decimator.sv]
// A sample beat accepted on the input is registered, then binned and written into
// the output queue once it has room, and can leave on the output port from there.
// Throughput: one input and one output beat per cycle while the queue has room and
// m_tready_i is high; the 4-entry queue absorbs the two-result bursts at bin ends.
// Reset (rst_ni low, async): queue and pipeline empty, line restarts at index 0,
// sample_count and pixel_width return to 1.
`timescale 1ns / 1ps

module min_max_bin_decimator import mmbd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  // [31:0] value, [63:32] position, [64] valid, [68:65] level, rest zero
  input  logic [TdataW-1:0]   s_tdata_i,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  // [31:0] value, [63:32] position, [64] valid, [68:65] level, rest zero
  output logic [TdataW-1:0]   m_tdata_o,
  output logic                m_tlast_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg;
  logic    restart;
  logic    room;
  push_t   push;
  result_t head;

  assign cfg_ready_o = 1'b1;

  mmbd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .restart_o   (restart)
  );

  mmbd_binner u_binner (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .restart_i   (restart),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .in_sample_i (sample_t'(s_tdata_i[SampleW-1:0])),
    .room_i      (room),
    .push_o      (push)
  );

  mmbd_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_o       (head)
  );

  assign m_tdata_o = {{(TdataW-SampleW){1'b0}}, head.s};
  assign m_tlast_o = head.last;

endmodule
